FILE: rtl/fmwa_pkg.sv
package fmwa_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SLOT_BITS    = $clog2(WINDOW_MAX);
   localparam int HELD_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int TIME_BITS    = 20;
   localparam int RATE_BITS    = 16;
   localparam int OBJ_BITS     = 10;
   localparam int OBJ_MEAN_BITS = 18;
   localparam int COUNT_BITS   = 32;
   localparam int NUM_METRICS  = 7;
   localparam int METRIC_BITS  = $clog2(NUM_METRICS);
   localparam int WSUM_BITS    = TIME_BITS + SLOT_BITS + 1;
   localparam int LSUM_BITS    = TIME_BITS + COUNT_BITS;
   localparam int DIV_BITS     = LSUM_BITS;
   localparam int STEP_BITS    = $clog2(DIV_BITS);
   localparam int CFG_BITS     = 7;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [METRIC_BITS-1:0] M_RATE    = METRIC_BITS'(5);
   localparam logic [METRIC_BITS-1:0] M_OBJECTS = METRIC_BITS'(6);

   typedef struct packed {
      logic [TIME_BITS-1:0] preprocess_us;
      logic [TIME_BITS-1:0] inference_us;
      logic [TIME_BITS-1:0] postprocess_us;
      logic [TIME_BITS-1:0] visualization_us;
      logic [TIME_BITS-1:0] end_to_end_us;
      logic [RATE_BITS-1:0] rate_q8;
      logic [OBJ_BITS-1:0]  objects;
   } frame_type;

   localparam int FRAME_BITS = $bits(frame_type);

   function automatic logic [LSUM_BITS-1:0] metric_of(frame_type f,
                                                       logic [METRIC_BITS-1:0] idx);
      logic [LSUM_BITS-1:0] v;
      case (idx)
         3'd0: v = LSUM_BITS'(f.preprocess_us);
         3'd1: v = LSUM_BITS'(f.inference_us);
         3'd2: v = LSUM_BITS'(f.postprocess_us);
         3'd3: v = LSUM_BITS'(f.visualization_us);
         3'd4: v = LSUM_BITS'(f.end_to_end_us);
         M_RATE: v = LSUM_BITS'(f.rate_q8);
         M_OBJECTS: v = LSUM_BITS'(f.objects);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/fmwa_ram.sv
module fmwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/frame_metrics_window_average.sv
// Moving and lifetime averages of per-frame metrics. Each accepted frame is
// stored in a 64-slot window RAM and added to window and lifetime sums; when
// the window holds more than csr_window_length frames (0 acts as 1, above 64
// as 64) the oldest is subtracted. Each frame then yields two result beats:
// the window mean (rsp_kind 0) and the lifetime mean (rsp_kind 1, rsp_last 1).
// All fourteen means come from one shared restoring divider; each quotient
// is preceded by a load step (ST_LOAD) that sets dividend and divisor. A frame
// runs from its acceptance through add, evict, fourteen loads and quotients,
// two result beats and the idle state before the next can be accepted, and the
// result beats may wait on rsp_ready; req_ready is low from acceptance until
// the second result beat is taken. The frame counter saturates at 2^32-1, and
// the lifetime sums freeze with it. No clearing pass after reset.
module frame_metrics_window_average_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_preprocess_us,
   input  logic [19:0] req_inference_us,
   input  logic [19:0] req_postprocess_us,
   input  logic [19:0] req_visualization_us,
   input  logic [19:0] req_end_to_end_us,
   input  logic [15:0] req_rate_q8,
   input  logic [9:0]  req_objects,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [19:0] rsp_mean_preprocess_us,
   output logic [19:0] rsp_mean_inference_us,
   output logic [19:0] rsp_mean_postprocess_us,
   output logic [19:0] rsp_mean_visualization_us,
   output logic [19:0] rsp_mean_end_to_end_us,
   output logic [15:0] rsp_mean_rate_q8,
   output logic [17:0] rsp_mean_objects_q8,
   output logic [31:0] rsp_frames_averaged,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_window_length
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD, ST_EVICT, ST_LOAD, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [fmwa_pkg::CFG_BITS-1:0]  wlen_ff, wlen_in;
   fmwa_pkg::frame_type            frame_ff, frame_in, req_frame, old_frame;
   logic                           evict_ff, evict_in;
   logic [fmwa_pkg::WSUM_BITS-1:0] wsum_ff [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::WSUM_BITS-1:0] wsum_in [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::LSUM_BITS-1:0] lsum_ff [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::LSUM_BITS-1:0] lsum_in [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [fmwa_pkg::HELD_BITS-1:0] held_ff, held_in;
   logic [fmwa_pkg::SLOT_BITS-1:0] newest_ff, newest_in, slot, oldest;
   logic [fmwa_pkg::HELD_BITS-1:0] eff_win;
   logic                           evict_now;
   logic                           kind_ff, kind_in;
   logic [fmwa_pkg::METRIC_BITS-1:0] mix_ff, mix_in;
   logic [fmwa_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [fmwa_pkg::DIV_BITS-1:0]  dvd_ff, dvd_in;
   logic [fmwa_pkg::COUNT_BITS-1:0] dvs_ff, dvs_in;
   logic [fmwa_pkg::COUNT_BITS-1:0] rem_ff, rem_in;
   logic [fmwa_pkg::COUNT_BITS:0]  rem_try;
   logic                           qbit;
   logic [fmwa_pkg::TIME_BITS-1:0] mean_ff [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::TIME_BITS-1:0] mean_in [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::LSUM_BITS-1:0] add_v [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::LSUM_BITS-1:0] old_v [fmwa_pkg::NUM_METRICS];
   logic [fmwa_pkg::LSUM_BITS-1:0] load_v;
   logic [fmwa_pkg::FRAME_BITS-1:0] rd_data;
   logic                           req_fire;

   assign req_frame = '{req_preprocess_us, req_inference_us, req_postprocess_us,
                        req_visualization_us, req_end_to_end_us, req_rate_q8,
                        req_objects};
   assign old_frame = fmwa_pkg::frame_type'(rd_data);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (wlen_ff == '0) begin
         eff_win = fmwa_pkg::HELD_BITS'(1);
      end else if (fmwa_pkg::HELD_BITS'(wlen_ff) >
                   fmwa_pkg::HELD_BITS'(fmwa_pkg::WINDOW_MAX)) begin
         eff_win = fmwa_pkg::HELD_BITS'(fmwa_pkg::WINDOW_MAX);
      end else begin
         eff_win = fmwa_pkg::HELD_BITS'(wlen_ff);
      end
   end

   assign evict_now = (held_ff + 1'b1 > eff_win) && (held_ff != '0);
   assign oldest    = newest_ff + 1'b1 - held_ff[fmwa_pkg::SLOT_BITS-1:0];
   assign slot      = (held_ff == '0) ? newest_ff : newest_ff + 1'b1;

   fmwa_ram #(.WIDTH(fmwa_pkg::FRAME_BITS), .DEPTH(fmwa_pkg::WINDOW_MAX)) u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_ADD),
      .wr_addr (newest_in),
      .wr_data (frame_ff),
      .rd_en   (req_fire),
      .rd_addr (oldest),
      .rd_data (rd_data)
   );

   assign rem_try = {rem_ff, dvd_ff[fmwa_pkg::DIV_BITS-1]} - {1'b0, dvs_ff};
   assign qbit    = !rem_try[fmwa_pkg::COUNT_BITS];

   always_comb begin
      for (int k = 0; k < fmwa_pkg::NUM_METRICS; k++) begin
         add_v[k] = fmwa_pkg::metric_of(frame_ff, fmwa_pkg::METRIC_BITS'(k));
         old_v[k] = fmwa_pkg::metric_of(old_frame, fmwa_pkg::METRIC_BITS'(k));
      end
      load_v = kind_ff ? lsum_ff[mix_ff] : fmwa_pkg::LSUM_BITS'(wsum_ff[mix_ff]);
      if (mix_ff == fmwa_pkg::M_OBJECTS) begin
         load_v = load_v << 8;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wlen_in   = wlen_ff;
      frame_in  = frame_ff;
      evict_in  = evict_ff;
      wsum_in   = wsum_ff;
      lsum_in   = lsum_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      newest_in = newest_ff;
      kind_in   = kind_ff;
      mix_in    = mix_ff;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      mean_in   = mean_ff;
      if (csr_valid) begin
         wlen_in = csr_window_length;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frame_in = req_frame;
               evict_in = evict_now;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            newest_in = slot;
            held_in   = held_ff + 1'b1 - fmwa_pkg::HELD_BITS'(evict_ff);
            for (int k = 0; k < fmwa_pkg::NUM_METRICS; k++) begin
               wsum_in[k] = wsum_ff[k] + add_v[k][fmwa_pkg::WSUM_BITS-1:0];
               if (count_ff != fmwa_pkg::COUNT_MAX) begin
                  lsum_in[k] = lsum_ff[k] + add_v[k];
               end
            end
            if (count_ff != fmwa_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (evict_ff) begin
               for (int k = 0; k < fmwa_pkg::NUM_METRICS; k++) begin
                  wsum_in[k] = (fmwa_pkg::LSUM_BITS'(wsum_ff[k]) >= old_v[k]) ?
                               wsum_ff[k] - old_v[k][fmwa_pkg::WSUM_BITS-1:0] : '0;
               end
            end
            kind_in  = 1'b0;
            mix_in   = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            dvd_in   = load_v;
            dvs_in   = kind_ff ? count_ff : fmwa_pkg::COUNT_BITS'(held_ff);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = qbit ? rem_try[fmwa_pkg::COUNT_BITS-1:0] :
                             {rem_ff[fmwa_pkg::COUNT_BITS-2:0], dvd_ff[fmwa_pkg::DIV_BITS-1]};
            dvd_in  = {dvd_ff[fmwa_pkg::DIV_BITS-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == fmwa_pkg::STEP_BITS'(fmwa_pkg::DIV_BITS - 1)) begin
               mean_in[mix_ff] = dvd_in[fmwa_pkg::TIME_BITS-1:0];
               if (mix_ff == fmwa_pkg::M_OBJECTS) begin
                  state_in = ST_OUT;
               end else begin
                  mix_in   = mix_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (kind_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  kind_in  = 1'b1;
                  mix_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wlen_ff   <= fmwa_pkg::WINDOW_RESET;
         count_ff  <= '0;
         held_ff   <= '0;
         newest_ff <= '0;
         kind_ff   <= 1'b0;
         mix_ff    <= '0;
         step_ff   <= '0;
         evict_ff  <= 1'b0;
         for (int k = 0; k < fmwa_pkg::NUM_METRICS; k++) begin
            wsum_ff[k] <= '0;
            lsum_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         wlen_ff   <= wlen_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
         newest_ff <= newest_in;
         kind_ff   <= kind_in;
         mix_ff    <= mix_in;
         step_ff   <= step_in;
         evict_ff  <= evict_in;
         wsum_ff   <= wsum_in;
         lsum_ff   <= lsum_in;
      end
      frame_ff <= frame_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      mean_ff  <= mean_in;
   end

   assign rsp_valid                 = (state_ff == ST_OUT);
   assign rsp_kind                  = kind_ff;
   assign rsp_last                  = kind_ff;
   assign rsp_mean_preprocess_us    = mean_ff[0];
   assign rsp_mean_inference_us     = mean_ff[1];
   assign rsp_mean_postprocess_us   = mean_ff[2];
   assign rsp_mean_visualization_us = mean_ff[3];
   assign rsp_mean_end_to_end_us    = mean_ff[4];
   assign rsp_mean_rate_q8          = mean_ff[fmwa_pkg::M_RATE][fmwa_pkg::RATE_BITS-1:0];
   assign rsp_mean_objects_q8       = mean_ff[fmwa_pkg::M_OBJECTS][fmwa_pkg::OBJ_MEAN_BITS-1:0];
   assign rsp_frames_averaged       = dvs_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= fmwa_pkg::HELD_BITS'(fmwa_pkg::WINDOW_MAX))
      else $error("window holds more frames than the store");

   a_held_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (held_ff != '0) && (count_ff != '0))
      else $error("result with an empty frame count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready while a frame is in work");

   a_window_after_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT && !evict_ff) |-> (held_ff <= eff_win))
      else $error("window larger than its length without eviction");

endmodule
